>>> src/mtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants, types and word functions of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int MTG_WORD_W      = 32;
    localparam int MTG_STATE_WORDS = 624;
    localparam int MTG_TWIST_MID   = 397;

    localparam logic [MTG_WORD_W-1:0] MTG_SEED_MULT    = 32'd1812433253;
    localparam logic [MTG_WORD_W-1:0] MTG_DEFAULT_SEED = 32'd5489;
    localparam logic [MTG_WORD_W-1:0] MTG_MATRIX       = 32'h9908b0df;
    localparam logic [MTG_WORD_W-1:0] MTG_UPPER_MASK   = 32'h80000000;
    localparam logic [MTG_WORD_W-1:0] MTG_LOWER_MASK   = 32'h7fffffff;
    localparam logic [MTG_WORD_W-1:0] MTG_TEMPER_B     = 32'h9d2c5680;
    localparam logic [MTG_WORD_W-1:0] MTG_TEMPER_C     = 32'hefc60000;

    localparam logic MTG_MODE_SEED = 1'b0;
    localparam logic MTG_MODE_DRAW = 1'b1;

    typedef enum logic [1:0] {
        ST_SEED,
        ST_IDLE,
        ST_PRIME,
        ST_TWIST
    } mtg_state_t;

    typedef struct packed {
        logic                  en;
        logic                  last;
        logic [MTG_WORD_W-1:0] data;
    } mtg_seed_wr_t;

    function automatic logic [MTG_WORD_W-1:0] mtg_twist(
        input logic [MTG_WORD_W-1:0] cur_word,
        input logic [MTG_WORD_W-1:0] nxt_word,
        input logic [MTG_WORD_W-1:0] mid_word
    );
        logic [MTG_WORD_W-1:0] y;
        logic [MTG_WORD_W-1:0] v;
        y = (cur_word & MTG_UPPER_MASK) | (nxt_word & MTG_LOWER_MASK);
        v = mid_word ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ MTG_MATRIX;
        end
        return v;
    endfunction

    function automatic logic [MTG_WORD_W-1:0] mtg_temper(input logic [MTG_WORD_W-1:0] w);
        logic [MTG_WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MTG_TEMPER_B);
        y = y ^ ((y << 15) & MTG_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> src/mtg_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_cmd_if
// Command channel: reseed or draw request with its seed word.
// ----------------------------------------------------------------------------
interface mtg_cmd_if
    import mtg_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [MTG_WORD_W-1:0] seed;

    modport source (output valid, output mode, output seed, input ready);
    modport sink (input valid, input mode, input seed, output ready);
endinterface

>>> src/mtg_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_rsp_if
// Response channel: one tempered word per draw.
// ----------------------------------------------------------------------------
interface mtg_rsp_if
    import mtg_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [MTG_WORD_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

>>> src/mtg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> src/mtg_seeder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_seeder
// Seeding sweep: one table word per cycle from the 1812433253 recurrence.
// ----------------------------------------------------------------------------
module mtg_seeder
    import mtg_pkg::*;
#(
    parameter int STATE_WORDS = MTG_STATE_WORDS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [MTG_WORD_W-1:0]          start_word,
    output mtg_seed_wr_t                   wr,
    output logic [$clog2(STATE_WORDS)-1:0] wr_addr
);
    localparam int IDX_W = $clog2(STATE_WORDS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

    logic                  active_reg;
    logic                  active_next;
    logic [IDX_W-1:0]      k_reg;
    logic [IDX_W-1:0]      k_next;
    logic [MTG_WORD_W-1:0] w_reg;
    logic [MTG_WORD_W-1:0] w_next;
    logic [MTG_WORD_W-1:0] mix;
    logic [MTG_WORD_W-1:0] prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            k_reg      <= '0;
            w_reg      <= MTG_DEFAULT_SEED;
        end
        else
        begin
            active_reg <= active_next;
            k_reg      <= k_next;
            w_reg      <= w_next;
        end
    end

    always_comb
    begin
        mix         = w_reg ^ (w_reg >> 30);
        prod        = MTG_WORD_W'(mix * MTG_SEED_MULT);
        active_next = active_reg;
        k_next      = k_reg;
        w_next      = w_reg;
        if (start)
        begin
            active_next = 1'b1;
            k_next      = '0;
            w_next      = start_word;
        end
        else if (active_reg)
        begin
            // word k+1 from word k
            w_next = prod + MTG_WORD_W'(k_reg) + MTG_WORD_W'(1);
            k_next = k_reg + IDX_W'(1);
            if (k_reg == LAST_IDX)
            begin
                active_next = 1'b0;
                k_next      = '0;
            end
        end
    end

    assign wr.en   = active_reg;
    assign wr.last = active_reg && (k_reg == LAST_IDX);
    assign wr.data = w_reg;
    assign wr_addr = k_reg;
endmodule

>>> src/mersenne_twister_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mersenne_twister_generator_unit
// MT19937 generator: state table in RAM, twisted one word per draw.
// ----------------------------------------------------------------------------
//  channel  dir  payload             beat
//  cmd      in   mode, seed[31:0]    mode 0 reseeds, mode 1 draws
//  rsp      out  value[31:0]         one tempered word per draw
//
//  a draw reads the next and middle words from two mirrored RAMs, then
//  twist, write and temper; the first draw after a seed primes the cache first
//  a reseed rewrites the table, one table write per cycle through the seeder
//  after reset the seeder sweeps the table with seed 5489,
//  cmd.ready is low meanwhile
//  a result held on rsp does not block the next beat on cmd
// ----------------------------------------------------------------------------
module mersenne_twister_generator_unit
    import mtg_pkg::*;
#(
    parameter int STATE_WORDS = MTG_STATE_WORDS
) (
    input  logic       clk,
    input  logic       rst_n,
    mtg_cmd_if.sink    cmd,
    mtg_rsp_if.source  rsp
);
    localparam int IDX_W = $clog2(STATE_WORDS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W:0]   MID_OFF   = (IDX_W + 1)'(MTG_TWIST_MID);
    localparam logic [IDX_W:0]   WORDS_EXT = (IDX_W + 1)'(STATE_WORDS);

    mtg_state_t            state_reg;
    mtg_state_t            state_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic                  cache_valid_reg;
    logic                  cache_valid_next;
    logic [MTG_WORD_W-1:0] cache_reg;
    logic [MTG_WORD_W-1:0] cache_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [MTG_WORD_W-1:0] out_value_reg;
    logic [MTG_WORD_W-1:0] out_value_next;

    logic                  cmd_fire;
    logic                  slot_free;
    logic [IDX_W-1:0]      nxt_idx;
    logic [IDX_W:0]        mid_sum;
    logic [IDX_W-1:0]      mid_idx;
    logic [IDX_W-1:0]      rd_addr_a;
    logic [MTG_WORD_W-1:0] rd_data_a;
    logic [MTG_WORD_W-1:0] rd_data_b;
    logic [MTG_WORD_W-1:0] twist_word;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [MTG_WORD_W-1:0] ram_wdata;

    logic                  seed_start;
    mtg_seed_wr_t          seed_wr;
    logic [IDX_W-1:0]      seed_addr;

    mtg_seeder #(
        .STATE_WORDS (STATE_WORDS)
    ) u_seeder (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (seed_start),
        .start_word (cmd.seed),
        .wr         (seed_wr),
        .wr_addr    (seed_addr)
    );

    // two mirrored copies give two read ports
    mtg_ram #(
        .WIDTH (MTG_WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    mtg_ram #(
        .WIDTH (MTG_WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (mid_idx),
        .rd_data (rd_data_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SEED;
            idx_reg         <= '0;
            cache_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            cache_valid_reg <= cache_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cache_reg     <= cache_next;
        out_value_reg <= out_value_next;
    end

    always_comb
    begin
        nxt_idx    = (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
        mid_sum    = {1'b0, idx_reg} + MID_OFF;
        mid_idx    = (mid_sum >= WORDS_EXT) ? IDX_W'(mid_sum - WORDS_EXT) : IDX_W'(mid_sum);
        rd_addr_a  = (state_reg == ST_IDLE && !cache_valid_reg) ? idx_reg : nxt_idx;
        twist_word = mtg_twist(cache_reg, rd_data_a, rd_data_b);
        cmd_fire   = cmd.valid && cmd.ready;
        slot_free  = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cache_valid_next = cache_valid_reg;
        cache_next       = cache_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_value_next   = out_value_reg;
        seed_start       = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = seed_addr;
        ram_wdata        = seed_wr.data;
        cmd.ready        = 1'b0;

        case (state_reg)
            ST_SEED:
            begin
                ram_we = seed_wr.en;
                if (seed_wr.last)
                begin
                    state_next       = ST_IDLE;
                    idx_next         = '0;
                    cache_valid_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd_fire)
                begin
                    if (cmd.mode == MTG_MODE_SEED)
                    begin
                        seed_start = 1'b1;
                        state_next = ST_SEED;
                    end
                    else if (cache_valid_reg)
                    begin
                        state_next = ST_TWIST;
                    end
                    else
                    begin
                        state_next = ST_PRIME;
                    end
                end
            end
            ST_PRIME:
            begin
                cache_next       = rd_data_a;
                cache_valid_next = 1'b1;
                state_next       = ST_TWIST;
            end
            ST_TWIST:
            begin
                if (slot_free)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = idx_reg;
                    ram_wdata      = twist_word;
                    out_valid_next = 1'b1;
                    out_value_next = mtg_temper(twist_word);
                    cache_next     = rd_data_a;
                    idx_next       = nxt_idx;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SEED;
            end
        endcase
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;
endmodule

>>> src/mtg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtg_checker
// Port-level checks of the MT19937 generator, bound to the top level.
// ----------------------------------------------------------------------------
module mtg_checker
    import mtg_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic                  cmd_mode,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [MTG_WORD_W-1:0] rsp_value
);
    logic cmd_fire;

    assign cmd_fire = cmd_valid && cmd_ready;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
        else $error("rsp beat dropped or changed while stalled");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> !cmd_ready)
        else $error("cmd taken again right after a beat");

    a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && cmd_mode == MTG_MODE_SEED && !rsp_valid |=> !rsp_valid)
        else $error("reseed produced a result");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!cmd_ready))
        else $error("result appeared while idle");
endmodule

bind mersenne_twister_generator_unit mtg_checker u_mtg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_mode  (cmd.mode),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_value (rsp.value)
);
